[rtl/crcbf_pkg.sv]
package crcbf_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NUM_LANES  = 8;
    localparam int unsigned BLOCK_BITS = WORD_W * NUM_LANES;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef crc_t [NUM_LANES-1:0] lane_crc_t;
    typedef crc_t [CRC_W-1:0]     crc_mat_t;
    typedef crc_t [WORD_W-1:0]    word_mat_t;
    typedef crc_mat_t [NUM_LANES-1:0] lane_mat_t;

    typedef struct packed {
        logic first_block;
        logic last_block;
        crc_t start_crc;
    } ctrl_t;

    // Runs the reflected CRC register over the given number of zero bits.
    function automatic crc_t crc_advance(crc_t c, int unsigned nbits);
        crc_t r;
        r = c;
        for (int unsigned n = 0; n < nbits; n++)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : '0);
        end
        return r;
    endfunction

    // Column i is the zero-start CRC of a word that has only bit i set.
    function automatic word_mat_t word_cols();
        word_mat_t m;
        for (int unsigned i = 0; i < WORD_W; i++)
        begin
            m[i] = crc_advance(crc_t'(1), WORD_W - i);
        end
        return m;
    endfunction

    function automatic crc_mat_t shift_cols(int unsigned nbits);
        crc_mat_t m;
        for (int unsigned k = 0; k < CRC_W; k++)
        begin
            m[k] = crc_advance(crc_t'(1) << k, nbits);
        end
        return m;
    endfunction

    // Lane j still has the words after it to pass through.
    function automatic lane_mat_t lane_shift_cols();
        lane_mat_t m;
        for (int unsigned j = 0; j < NUM_LANES; j++)
        begin
            m[j] = shift_cols(WORD_W * (NUM_LANES - 1 - j));
        end
        return m;
    endfunction

    function automatic crc_t mat_apply(crc_mat_t m, crc_t v);
        crc_t r;
        r = '0;
        for (int unsigned k = 0; k < CRC_W; k++)
        begin
            r = r ^ (v[k] ? m[k] : '0);
        end
        return r;
    endfunction

endpackage

[rtl/crcbf_if.sv]
interface crcbf_blk_if;
    import crcbf_pkg::*;

    logic  valid;
    logic  ready;
    word_t word0;
    word_t word1;
    word_t word2;
    word_t word3;
    word_t word4;
    word_t word5;
    word_t word6;
    word_t word7;
    logic  first_block;
    crc_t  start_crc;
    logic  last_block;

    modport source (
        output valid, word0, word1, word2, word3, word4, word5, word6, word7,
               first_block, start_crc, last_block,
        input  ready
    );

    modport sink (
        input  valid, word0, word1, word2, word3, word4, word5, word6, word7,
               first_block, start_crc, last_block,
        output ready
    );
endinterface

interface crcbf_res_if;
    import crcbf_pkg::*;

    logic valid;
    logic ready;
    crc_t crc_value;

    modport source (
        output valid, crc_value,
        input  ready
    );

    modport sink (
        input  valid, crc_value,
        output ready
    );
endinterface

[rtl/crcbf_lane.sv]
module crcbf_lane (
    input  logic            clk,
    input  logic            load,
    input  crcbf_pkg::word_t word,
    output crcbf_pkg::crc_t  lane_crc
);
    import crcbf_pkg::*;

    localparam word_mat_t COLS = word_cols();

    crc_t crc_reg;
    crc_t crc_next;

    always_comb
    begin
        crc_next = '0;
        for (int unsigned i = 0; i < WORD_W; i++)
        begin
            crc_next = crc_next ^ (word[i] ? COLS[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            crc_reg <= crc_next;
        end
    end

    assign lane_crc = crc_reg;

endmodule

[rtl/crcbf_merge.sv]
module crcbf_merge (
    input  logic                 clk,
    input  logic                 load,
    input  crcbf_pkg::lane_crc_t lane_crc,
    output crcbf_pkg::crc_t      block_crc
);
    import crcbf_pkg::*;

    localparam lane_mat_t SHIFTS = lane_shift_cols();

    crc_t sum_reg;
    crc_t sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int unsigned j = 0; j < NUM_LANES; j++)
        begin
            sum_next = sum_next ^ mat_apply(SHIFTS[j], lane_crc[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign block_crc = sum_reg;

endmodule

[rtl/crc32_block_fold_core.sv]
// Running CRC-32 (reflected polynomial 0xEDB88320, no inversion) over a
// stream of 64-byte blocks.
// The blk channel takes one word per block: eight 64-bit data words, byte 0
// in the low byte of word0, with first_block, start_crc and last_block.
// A block with first_block set starts from start_crc; any other block
// continues from the stored CRC register.
// The res channel gives one word, crc_value, for each block that has
// last_block set, and nothing for the other blocks.
// A block taken on blk passes through the lane registers and the merge register, and its result is registered for res.
// The block takes one word every cycle unless res back-pressure fills it: the eight
// lanes and the merge are pipelined, and the only feedback is the one 32-by-32 XOR
// matrix that advances the stored CRC across 512 bits.
// When res is stalled, the held result and the two pipeline stages still
// take new blocks; blk.ready drops only when all three are full.
// Reset empties the pipeline and clears the CRC register to zero.
module crc32_block_fold_core (
    input  logic clk,
    input  logic rst_n,
    crcbf_blk_if.sink   blk,
    crcbf_res_if.source res
);
    import crcbf_pkg::*;

    localparam crc_mat_t STATE_COLS = shift_cols(BLOCK_BITS);

    word_t [NUM_LANES-1:0] words;
    lane_crc_t lane_crc;
    crc_t      block_crc;

    logic  s1_valid_reg;
    logic  s1_valid_next;
    logic  s2_valid_reg;
    logic  s2_valid_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    ctrl_t s1_ctrl_reg;
    ctrl_t s2_ctrl_reg;
    crc_t  crc_reg;
    crc_t  crc_next;
    crc_t  out_crc_reg;

    logic take;
    logic adv1;
    logic adv2;
    logic s2_free;
    logic s1_free;

    assign words = {blk.word7, blk.word6, blk.word5, blk.word4,
                    blk.word3, blk.word2, blk.word1, blk.word0};

    assign adv2    = s2_valid_reg
                     && (!s2_ctrl_reg.last_block || !out_valid_reg || res.ready);
    assign s2_free = !s2_valid_reg || adv2;
    assign adv1    = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign take    = blk.valid && s1_free;

    assign blk.ready = s1_free;

    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        crcbf_lane u_lane (
            .clk      (clk),
            .load     (take),
            .word     (words[j]),
            .lane_crc (lane_crc[j])
        );
    end

    crcbf_merge u_merge (
        .clk       (clk),
        .load      (adv1),
        .lane_crc  (lane_crc),
        .block_crc (block_crc)
    );

    always_comb
    begin
        crc_next = mat_apply(STATE_COLS,
                             s2_ctrl_reg.first_block ? s2_ctrl_reg.start_crc : crc_reg)
                   ^ block_crc;
        s1_valid_next  = take ? 1'b1 : (adv1 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = adv1 ? 1'b1 : (adv2 ? 1'b0 : s2_valid_reg);
        out_valid_next = (adv2 && s2_ctrl_reg.last_block) ? 1'b1
                         : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv2)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ctrl_reg.first_block <= blk.first_block;
            s1_ctrl_reg.last_block  <= blk.last_block;
            s1_ctrl_reg.start_crc   <= blk.start_crc;
        end
        if (adv1)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
        if (adv2 && s2_ctrl_reg.last_block)
        begin
            out_crc_reg <= crc_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.crc_value = out_crc_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !blk.ready |-> s1_valid_reg && s2_valid_reg && out_valid_reg)
        else $error("input stalled while the pipeline has room");

    a_emit_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        adv2 && s2_ctrl_reg.last_block |=> out_valid_reg && (out_crc_reg == crc_reg))
        else $error("emitted CRC differs from the updated register");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv2 |=> $stable(crc_reg))
        else $error("CRC register changed without a block");

endmodule

[tb/crc32_block_fold_checker.sv]
`timescale 1ns / 100ps

module crc32_block_fold_checker (
    input  logic        clk,
    input  logic        rst_n,
    crcbf_blk_if        blk,
    crcbf_res_if        res,
    output int          errors,
    output int          pending,
    output int          blocks_seen,
    output int          crcs_seen
);
    import crcbf_pkg::*;

    crc_t running_crc = '0;
    crc_t crc_due [$];

    // Reflected CRC register run over the block one bit at a time, byte 0 first.
    function automatic crc_t crc_fold_block(crc_t seed, logic [BLOCK_BITS-1:0] data);
        crc_t c;
        c = seed;
        for (int i = 0; i < BLOCK_BITS; i++)
        begin
            c = (c >> 1) ^ ((c[0] ^ data[i]) ? CRC_POLY : '0);
        end
        return c;
    endfunction

    task automatic flag_crc_error(string what, crc_t want, crc_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("Mismatch %0d at %0t: %s, expected crc_value %08h, got %08h",
                     errors, $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        crc_t want;
        if (!rst_n)
        begin
            running_crc = '0;
            crc_due.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                crcs_seen++;
                if (crc_due.size() == 0)
                begin
                    flag_crc_error("result word with no block pending", 'x, res.crc_value);
                end
                else
                begin
                    want = crc_due.pop_front();
                    if (res.crc_value !== want)
                    begin
                        flag_crc_error("wrong CRC value", want, res.crc_value);
                    end
                end
            end
            if (blk.valid && blk.ready)
            begin
                blocks_seen++;
                running_crc = crc_fold_block(blk.first_block ? blk.start_crc : running_crc,
                                             {blk.word7, blk.word6, blk.word5, blk.word4,
                                              blk.word3, blk.word2, blk.word1, blk.word0});
                if (blk.last_block)
                begin
                    crc_due.push_back(running_crc);
                end
            end
        end
        pending = crc_due.size();
    end

endmodule

[tb/tb_crc32_block_fold_core.sv]
`timescale 1ns / 100ps

module tb_crc32_block_fold_core;
    import crcbf_pkg::*;

    localparam int BLOCK_COUNT  = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int BURST_BLOCKS = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int FLUSH_CYCLES = 10;

    typedef word_t [NUM_LANES-1:0] block_t;

    logic clk;
    logic rst_n;

    crcbf_blk_if blk ();
    crcbf_res_if res ();

    int errors;
    int pending;
    int blocks_seen;
    int crcs_seen;
    int sent;
    int messages;
    int quiet_cycles;
    bit idle_on;
    bit hold_req;

    crc32_block_fold_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .blk   (blk),
        .res   (res)
    );

    crc32_block_fold_checker crc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .blk         (blk),
        .res         (res),
        .errors      (errors),
        .pending     (pending),
        .blocks_seen (blocks_seen),
        .crcs_seen   (crcs_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic block_t rand_block();
        block_t w;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            w[i] = rand_word();
        end
        return w;
    endfunction

    function automatic block_t fill_block(word_t v);
        block_t w;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            w[i] = v;
        end
        return w;
    endfunction

    function automatic crc_t pick_seed();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word is accepted.
    task automatic send_block(block_t words, logic first, crc_t start, logic last);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            blk.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk.valid       <= 1'b1;
        blk.word0       <= words[0];
        blk.word1       <= words[1];
        blk.word2       <= words[2];
        blk.word3       <= words[3];
        blk.word4       <= words[4];
        blk.word5       <= words[5];
        blk.word6       <= words[6];
        blk.word7       <= words[7];
        blk.first_block <= first;
        blk.start_crc   <= start;
        blk.last_block  <= last;
        @(negedge clk);
        while (!blk.ready) @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    task automatic send_message(int nblocks);
        crc_t seed;
        seed = pick_seed();
        for (int i = 0; i < nblocks; i++)
        begin
            send_block(rand_block(), i == 0, (i == 0) ? seed : crc_t'($urandom),
                       i == nblocks - 1);
        end
        messages++;
    endtask

    initial
    begin
        int n;
        logic rdy;
        res.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rdy = 1'b0;
                n = HOLD_CYCLES;
            end
            else if (!idle_on)
            begin
                rdy = 1'b1;
                n = 1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                rdy = 1'b0;
                n = pick_gap();
                if (n == 0)
                    n = 1;
            end
            else
            begin
                rdy = 1'b1;
                n = $urandom_range(1, 8);
            end
            res.ready <= rdy;
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((blk.valid && blk.ready) || (res.valid && res.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        block_t w;
        bit saved_idle;
        rst_n = 1'b0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        sent = 0;
        messages = 0;
        blk.valid       <= 1'b0;
        blk.word0       <= '0;
        blk.word1       <= '0;
        blk.word2       <= '0;
        blk.word3       <= '0;
        blk.word4       <= '0;
        blk.word5       <= '0;
        blk.word6       <= '0;
        blk.word7       <= '0;
        blk.first_block <= 1'b0;
        blk.start_crc   <= '0;
        blk.last_block  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blocks before any first block continue from the cleared register.
        send_block('0, 1'b0, 32'h1234_5678, 1'b1);
        send_block(fill_block('1), 1'b0, '1, 1'b1);
        send_block('0, 1'b1, '1, 1'b1);
        send_block(fill_block('1), 1'b1, '0, 1'b1);
        send_block(fill_block('1), 1'b1, '1, 1'b1);
        send_block(fill_block(64'h5555_5555_5555_5555), 1'b1, 32'hA5A5_A5A5, 1'b1);
        send_block(fill_block(64'hAAAA_AAAA_AAAA_AAAA), 1'b1, 32'h5A5A_5A5A, 1'b0);
        send_block(fill_block(64'h0123_4567_89AB_CDEF), 1'b0, '1, 1'b0);
        send_block(fill_block(64'hFEDC_BA98_7654_3210), 1'b0, '0, 1'b1);
        // The register keeps its value after an emit and the stream goes on.
        send_block(fill_block(64'h8000_0000_0000_0001), 1'b0, '1, 1'b1);
        send_block('0, 1'b0, '0, 1'b1);
        // A first block in the middle of a message restarts it.
        send_block(fill_block(64'hDEAD_BEEF_CAFE_F00D), 1'b1, '1, 1'b0);
        send_block(fill_block(64'h0F0F_0F0F_0F0F_0F0F), 1'b1, 32'h0000_0001, 1'b1);
        w = '0;
        w[0] = 64'h1;
        send_block(w, 1'b1, '0, 1'b1);
        w = '0;
        w[7] = 64'h8000_0000_0000_0000;
        send_block(w, 1'b1, '0, 1'b1);
        w = '0;
        w[3] = 64'h8000_0000_0000_0000;
        w[4] = 64'h1;
        send_block(w, 1'b1, 32'h8000_0000, 1'b1);
        send_block('0, 1'b1, 32'h8000_0000, 1'b1);
        messages = 17;

        while (sent < BLOCK_COUNT)
        begin
            idle_on = ((sent / 150) % 4) != 3;
            if (sent >= 400 && sent < 420)
            begin
                // Hold the result side off while blocks keep coming.
                saved_idle = idle_on;
                idle_on = 1'b0;
                hold_req = 1'b1;
                for (int i = 0; i < BURST_BLOCKS; i++)
                begin
                    send_message(1);
                end
                idle_on = saved_idle;
            end
            else if (sent >= 800 && sent < 812)
            begin
                blk.valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
                send_message(2);
            end
            else if ($urandom_range(0, 99) < 85)
            begin
                send_message(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                          : $urandom_range(1, 4));
            end
            else
            begin
                send_block(rand_block(), 1'($urandom_range(0, 1)), crc_t'($urandom),
                           1'($urandom_range(0, 1)));
            end
        end

        blk.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (FLUSH_CYCLES) @(posedge clk);

        $display("Run covered %0d blocks in about %0d messages and %0d CRC results,",
                 blocks_seen, messages, crcs_seen);
        $display("with random gaps, back-to-back bursts and a %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
